### hdl/alx_pkg.sv
// Shared types, character constants and classification helpers for the assembler lexer.
package alx_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_IDENT   = 3'd2,
        MODE_DEC     = 3'd3,
        MODE_ZERO    = 3'd4,
        MODE_HEX     = 3'd5,
        MODE_BIN     = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        KIND_NUM   = 2'd0,
        KIND_IDENT = 2'd1,
        KIND_OP    = 2'd2,
        KIND_END   = 2'd3
    } t_kind;

    typedef struct packed {
        logic       valid;
        logic [7:0] ch;
        logic       start;
        t_kind      kind;
        t_mode      next_mode;
    } t_step_res;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_B    = 8'h42;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [7:0] CH_UP_X    = 8'h58;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_B    = 8'h62;
    localparam logic [7:0] CH_LO_F    = 8'h66;
    localparam logic [7:0] CH_LO_X    = 8'h78;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;
    localparam logic [7:0] CH_NUL     = 8'h00;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= CH_LO_A) && (c <= CH_LO_Z);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return is_lower(c) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= CH_LO_A) && (c <= CH_LO_F))
            || ((c >= CH_UP_A) && (c <= CH_UP_F));
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return is_lower(c) ? (c - CASE_DIFF) : c;
    endfunction

endpackage

### hdl/alx_step.sv
// Combinational lexer step: classifies one byte against the current mode.
module alx_step
    import alx_pkg::*;
(
    input  logic [7:0] i_char,
    input  logic       i_eoi,
    input  t_mode      i_mode,
    output t_step_res  o_res
);

    t_step_res idle_res;

    // Handling of a byte when no token is open; also used when a token is ended
    // by a byte that cannot continue it.
    always_comb begin
        idle_res.valid     = 1'b1;
        idle_res.ch        = i_char;
        idle_res.start     = 1'b1;
        idle_res.kind      = KIND_OP;
        idle_res.next_mode = MODE_IDLE;
        if (i_char == CH_SPACE || i_char == CH_TAB || i_char == CH_CR) begin
            idle_res.valid = 1'b0;
        end else if (i_char == CH_PERCENT) begin
            idle_res.valid     = 1'b0;
            idle_res.next_mode = MODE_COMMENT;
        end else if (is_digit(i_char)) begin
            idle_res.kind      = KIND_NUM;
            idle_res.next_mode = (i_char == CH_ZERO) ? MODE_ZERO : MODE_DEC;
        end else if (is_alpha(i_char) || i_char == CH_UNDER) begin
            idle_res.ch        = to_upper(i_char);
            idle_res.kind      = KIND_IDENT;
            idle_res.next_mode = MODE_IDENT;
        end
    end

    always_comb begin
        o_res = idle_res;
        if (i_eoi) begin
            o_res.valid     = 1'b1;
            o_res.ch        = CH_NUL;
            o_res.start     = 1'b1;
            o_res.kind      = KIND_END;
            o_res.next_mode = MODE_IDLE;
        end else begin
            case (i_mode)
                MODE_COMMENT: begin
                    if (i_char == CH_LF) begin
                        o_res = idle_res;
                    end else begin
                        o_res.valid     = 1'b0;
                        o_res.next_mode = MODE_COMMENT;
                    end
                end
                MODE_IDENT: begin
                    if (is_alpha(i_char) || is_digit(i_char) || i_char == CH_UNDER) begin
                        o_res.ch        = to_upper(i_char);
                        o_res.start     = 1'b0;
                        o_res.kind      = KIND_IDENT;
                        o_res.next_mode = MODE_IDENT;
                    end
                end
                MODE_DEC: begin
                    if (is_digit(i_char)) begin
                        o_res.ch        = i_char;
                        o_res.start     = 1'b0;
                        o_res.kind      = KIND_NUM;
                        o_res.next_mode = MODE_DEC;
                    end
                end
                MODE_ZERO: begin
                    if (i_char == CH_LO_X || i_char == CH_UP_X) begin
                        o_res.ch        = CH_UP_X;
                        o_res.start     = 1'b0;
                        o_res.kind      = KIND_NUM;
                        o_res.next_mode = MODE_HEX;
                    end else if (i_char == CH_LO_B || i_char == CH_UP_B) begin
                        o_res.ch        = CH_UP_B;
                        o_res.start     = 1'b0;
                        o_res.kind      = KIND_NUM;
                        o_res.next_mode = MODE_BIN;
                    end else if (is_digit(i_char)) begin
                        o_res.ch        = i_char;
                        o_res.start     = 1'b0;
                        o_res.kind      = KIND_NUM;
                        o_res.next_mode = MODE_DEC;
                    end
                end
                MODE_HEX: begin
                    if (is_hex(i_char)) begin
                        o_res.ch        = to_upper(i_char);
                        o_res.start     = 1'b0;
                        o_res.kind      = KIND_NUM;
                        o_res.next_mode = MODE_HEX;
                    end
                end
                MODE_BIN: begin
                    if (i_char == CH_ZERO || i_char == CH_ONE) begin
                        o_res.ch        = i_char;
                        o_res.start     = 1'b0;
                        o_res.kind      = KIND_NUM;
                        o_res.next_mode = MODE_BIN;
                    end
                end
                default: begin
                    o_res = idle_res;
                end
            endcase
        end
    end

endmodule

### hdl/assembler_lexer.sv
// Streaming assembler lexer top level: input register, step logic and result register.
//
// The slave channel takes one source byte per transfer in s_axis_tdata, with
// s_axis_tuser marking end of input. The master channel gives one result per kept
// byte: the upper-cased byte in m_axis_tdata, and in m_axis_tuser the token start
// flag and the token kind (number, identifier, operator, end marker).
// Blanks and comment bytes produce no result transfer.
// A byte accepted into the input register is classified there by the step logic;
// its result is written to the result register and offered on the master side.
// Throughput is one byte per cycle if the receiver keeps up; the only feedback is
// the 3-bit lexer mode, updated in the same cycle the byte leaves the input register.
// When the receiver stalls, the result register holds its transfer and the input
// register keeps one byte; s_axis_tready drops only when both are full and the
// held byte would produce a result. Bytes that produce no result still drain.
// Reset empties both registers and returns the mode to idle between tokens.
module assembler_lexer
    import alx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_char
    input  logic [0:0] s_axis_tuser,   // [0] end_of_input
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic [2:0] m_axis_tuser    // [0] token_start, [2:1] token_kind
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_eoi;
    t_mode      r_mode;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_start;
    t_kind      r_out_kind;

    t_step_res  step;
    logic       out_room;
    logic       advance;

    alx_step u_step (
        .i_char (r_in_char),
        .i_eoi  (r_in_eoi),
        .i_mode (r_mode),
        .o_res  (step)
    );

    assign out_room      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && (!step.valid || out_room);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
            r_in_eoi  <= s_axis_tuser[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
        end else if (advance) begin
            r_mode <= step.next_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step.valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step.valid) begin
            r_out_char  <= step.ch;
            r_out_start <= step.start;
            r_out_kind  <= step.kind;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tuser  = {r_out_kind, r_out_start};

    // The end marker is always a zero byte that starts its own token.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2:1] == KIND_END)
            |-> (m_axis_tdata == CH_NUL && m_axis_tuser[0]))
        else $error("end marker malformed");

    // Only numbers and identifiers have continuation bytes.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0])
            |-> (m_axis_tuser[2:1] == KIND_NUM || m_axis_tuser[2:1] == KIND_IDENT))
        else $error("continuation byte on a one-byte token kind");

    // End of input always leaves the lexer idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_eoi) |=> (r_mode == MODE_IDLE))
        else $error("mode not idle after end of input");

    // Inside a comment only a newline or end of input produces a result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_mode == MODE_COMMENT && !r_in_eoi && r_in_char != CH_LF)
            |-> !step.valid)
        else $error("comment byte produced a result");

    // A held byte is never dropped while it waits for room downstream.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_char) && $stable(r_mode)))
        else $error("stalled input byte lost");

endmodule
